### sv/pdct_pkg.sv
package pdct_pkg;

    // Core sizes
    localparam int CHAR_BITS = 8;
    localparam int TIME_BITS = 16;
    localparam int LEFT_W    = (CHAR_BITS > 1) ? $clog2(CHAR_BITS) : 1;

    // Port field widths
    localparam int OPCODE_W  = 2;
    localparam int CODE_IN_W = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [CHAR_BITS-1:0] code_t;
    typedef logic [TIME_BITS-1:0] tick_t;
    typedef logic [LEFT_W-1:0]    left_t;
    typedef logic [CFG_W-1:0]     cfg_word_t;

    // Opcodes on the command channel
    localparam logic [OPCODE_W-1:0] OPC_TICK    = 2'd0;
    localparam logic [OPCODE_W-1:0] OPC_CHAR    = 2'd1;
    localparam logic [OPCODE_W-1:0] OPC_SESSION = 2'd2;

    // Timing register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_GAP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_GAP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHAR_GAP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SESSION_GAP = 3'd4;

    // Timing register reset values
    localparam cfg_word_t RST_ZERO_GAP    = 16'd10;
    localparam cfg_word_t RST_ONE_GAP     = 16'd20;
    localparam cfg_word_t RST_PULSE       = 16'd5;
    localparam cfg_word_t RST_CHAR_GAP    = 16'd40;
    localparam cfg_word_t RST_SESSION_GAP = 16'd80;

    // Decoded command kinds
    typedef enum logic [3:0] {
        KIND_TICK    = 4'b0001,
        KIND_CHAR    = 4'b0010,
        KIND_SESSION = 4'b0100,
        KIND_NOP     = 4'b1000
    } word_kind_t;

    // One decoded command word, as queued for the back end
    typedef struct packed {
        word_kind_t kind;
        code_t      shf;   // significant bits, current bit at the MSB
        left_t      left;  // data bits after the current one
    } word_t;

    typedef struct packed {
        tick_t zero_gap;
        tick_t one_gap;
        tick_t pulse;
        tick_t char_gap;
        tick_t session_gap;
    } timing_t;

    typedef struct packed {
        logic busy;
        logic cnt_zero;
    } back_stat_t;

endpackage

### sv/pdct_ifs.sv
interface pdct_in_if;
    import pdct_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OPCODE_W-1:0]     opcode;
    logic [CODE_IN_W-1:0]    char_code;

    modport source (output valid, output opcode, output char_code, input ready);
    modport sink   (input valid, input opcode, input char_code, output ready);
endinterface

interface pdct_out_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic rejected;

    modport source (output valid, output line_level, output busy_res, output rejected,
                    input ready);
    modport sink   (input valid, input line_level, input busy_res, input rejected,
                    output ready);
endinterface

interface pdct_cfg_if;
    import pdct_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/pdct_front.sv
module pdct_front (
    pdct_in_if.sink          cmd,
    input  logic             q_ready,
    output logic             push,
    output pdct_pkg::word_t  push_word
);
    import pdct_pkg::*;

    code_t code;
    left_t hi;

    assign cmd.ready = q_ready;
    assign push      = cmd.valid && q_ready;

    // Normalize the code: drop leading zeros, keep at least one bit
    always_comb
    begin
        code = code_t'(cmd.char_code);
        hi   = '0;
        for (int i = 0; i < CHAR_BITS; i++)
        begin
            if (code[i])
            begin
                hi = LEFT_W'(i);
            end
        end
    end

    always_comb
    begin
        push_word.shf  = code << (LEFT_W'(CHAR_BITS - 1) - hi);
        push_word.left = hi;
        unique case (cmd.opcode)
            OPC_TICK:    push_word.kind = KIND_TICK;
            OPC_CHAR:    push_word.kind = KIND_CHAR;
            OPC_SESSION: push_word.kind = KIND_SESSION;
            default:     push_word.kind = KIND_NOP;
        endcase
    end

endmodule

### sv/pdct_queue.sv
module pdct_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pdct_pkg::word_t  push_word,
    output logic             ready,
    input  logic             pop,
    output logic             head_valid,
    output pdct_pkg::word_t  head_word
);
    import pdct_pkg::*;

    word_t              ent_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg;

    assign ready      = (cnt_reg != QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_word  = ent_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

### sv/pdct_back.sv
module pdct_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pdct_pkg::timing_t    timing,
    input  logic                 head_valid,
    input  pdct_pkg::word_t      head_word,
    output logic                 pop,
    output pdct_pkg::back_stat_t stat,
    pdct_out_if.source           result
);
    import pdct_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_GAP   = 3'b010,
        PH_PULSE = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        CK_DATA    = 3'b001,
        CK_CHAR    = 3'b010,
        CK_SESSION = 3'b100
    } close_t;

    typedef struct packed {
        phase_t phase;
        tick_t  cnt;
        code_t  shf;
        left_t  left;
        close_t kind;
    } seg_t;

    seg_t  state_reg;
    seg_t  state_next;
    tick_t dec;
    logic  level_next;
    logic  rej_next;
    logic  out_valid_reg;
    logic  level_reg;
    logic  busy_reg;
    logic  rej_reg;

    function automatic tick_t gap_of(logic b, timing_t t);
        return b ? t.one_gap : t.zero_gap;
    endfunction

    // Enter a closing gap; skip it and its pulse when they are zero long
    function automatic seg_t close_seg(seg_t base, tick_t g, close_t k, timing_t t);
        seg_t r;
        r      = base;
        r.kind = k;
        if (g != '0)
        begin
            r.phase = PH_GAP;
            r.cnt   = g;
        end
        else if (t.pulse != '0)
        begin
            r.phase = PH_PULSE;
            r.cnt   = t.pulse;
        end
        else
        begin
            r.phase = PH_IDLE;
            r.cnt   = '0;
            r.kind  = CK_DATA;
        end
        return r;
    endfunction

    // Enter the current data bit; with zero pulses, search ahead for the
    // first bit whose gap is not zero, else fall into the character break
    function automatic seg_t data_seg(code_t s, left_t l, timing_t t);
        seg_t  r;
        logic  found;
        left_t jj;
        tick_t g;
        r.phase = PH_IDLE;
        r.cnt   = '0;
        r.shf   = s;
        r.left  = l;
        r.kind  = CK_DATA;
        found   = 1'b0;
        jj      = '0;
        g       = gap_of(s[CHAR_BITS-1], t);
        if (t.pulse != '0)
        begin
            if (g != '0)
            begin
                r.phase = PH_GAP;
                r.cnt   = g;
            end
            else
            begin
                r.phase = PH_PULSE;
                r.cnt   = t.pulse;
            end
        end
        else
        begin
            for (int j = 0; j < CHAR_BITS; j++)
            begin
                if (!found && (LEFT_W'(j) <= l) &&
                    (gap_of(s[CHAR_BITS-1-j], t) != '0))
                begin
                    found = 1'b1;
                    jj    = LEFT_W'(j);
                end
            end
            if (found)
            begin
                r.shf   = s << jj;
                r.left  = l - jj;
                r.phase = PH_GAP;
                r.cnt   = gap_of(r.shf[CHAR_BITS-1], t);
            end
            else
            begin
                r = close_seg(r, t.char_gap, CK_CHAR, t);
            end
        end
        return r;
    endfunction

    // Leave a pulse: next data bit, character break, or idle
    function automatic seg_t after_pulse(seg_t c, timing_t t);
        seg_t r;
        r = c;
        if (c.kind == CK_DATA && c.left != '0)
        begin
            r = data_seg(c.shf << 1, c.left - 1'b1, t);
        end
        else if (c.kind == CK_DATA)
        begin
            r = close_seg(c, t.char_gap, CK_CHAR, t);
        end
        else
        begin
            r.phase = PH_IDLE;
            r.cnt   = '0;
            r.kind  = CK_DATA;
        end
        return r;
    endfunction

    assign pop           = head_valid && (!out_valid_reg || result.ready);
    assign dec           = state_reg.cnt - 1'b1;
    assign stat.busy     = (state_reg.phase != PH_IDLE);
    assign stat.cnt_zero = (state_reg.cnt == '0);

    always_comb
    begin
        state_next = state_reg;
        rej_next   = 1'b0;
        level_next = 1'b0;
        unique case (head_word.kind)
            KIND_TICK:
            begin
                if (state_reg.phase != PH_IDLE)
                begin
                    if (dec != '0)
                    begin
                        state_next.cnt = dec;
                    end
                    else if (state_reg.phase == PH_GAP && timing.pulse != '0)
                    begin
                        state_next.phase = PH_PULSE;
                        state_next.cnt   = timing.pulse;
                    end
                    else
                    begin
                        state_next = after_pulse(state_reg, timing);
                    end
                end
            end
            KIND_CHAR:
            begin
                if (state_reg.phase != PH_IDLE)
                begin
                    rej_next = 1'b1;
                end
                else
                begin
                    state_next = data_seg(head_word.shf, head_word.left, timing);
                end
            end
            KIND_SESSION:
            begin
                if (state_reg.phase != PH_IDLE)
                begin
                    rej_next = 1'b1;
                end
                else
                begin
                    state_next = close_seg(state_reg, timing.session_gap, CK_SESSION, timing);
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
        // A tick reports the level it spent; anything else the level it leaves
        if (head_word.kind == KIND_TICK)
        begin
            level_next = (state_reg.phase == PH_PULSE);
        end
        else
        begin
            level_next = (state_next.phase == PH_PULSE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase <= PH_IDLE;
            state_reg.cnt   <= '0;
            state_reg.shf   <= '0;
            state_reg.left  <= '0;
            state_reg.kind  <= CK_DATA;
            out_valid_reg   <= 1'b0;
        end
        else if (pop)
        begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            level_reg <= level_next;
            busy_reg  <= (state_next.phase != PH_IDLE);
            rej_reg   <= rej_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.line_level = level_reg;
    assign result.busy_res   = busy_reg;
    assign result.rejected   = rej_reg;

endmodule

### sv/pulse_distance_char_transmitter.sv
// Pulse-distance character transmitter, stepped in time by tick words.
//
// Channels (valid/ready, a word moves when both are high at a rising edge):
//   cmd    : opcode (tick, send character, send session end) and char_code.
//   result : one word per cmd word: line_level, busy_res, rejected.
//   cfg    : timing register writes (index, data); always ready. Write only
//            while the transmitter is idle and no result is outstanding.
// Each character goes out MSB first with leading zeros dropped; every bit is
// a low gap (zero or one length) and a high pulse, then a character-break gap
// and pulse. Zero-length segments are skipped within the same word.
//
// Throughput: one cmd word per cycle while the receiver takes result words; a
// stall at the result channel holds the flow. Each cmd word passes through the
// two-word queue and then the output register before its result word is valid.
// Reset: timing registers return to their defaults, the line goes idle, the
// queue and output register empty. If the receiver stalls, the output
// register holds its word, the queue fills, and cmd.ready drops.
module pulse_distance_char_transmitter (
    input  logic        clk,
    input  logic        rst_n,
    pdct_in_if.sink     cmd,
    pdct_out_if.source  result,
    pdct_cfg_if.sink    cfg
);
    import pdct_pkg::*;

    cfg_word_t  zero_gap_reg;
    cfg_word_t  one_gap_reg;
    cfg_word_t  pulse_reg;
    cfg_word_t  char_gap_reg;
    cfg_word_t  session_gap_reg;
    timing_t    timing;

    logic       q_ready;
    logic       push;
    word_t      push_word;
    logic       pop;
    logic       q_head_valid;
    word_t      q_head_word;
    back_stat_t stat;

    // Timing registers: take every write, drop unknown indexes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_gap_reg    <= RST_ZERO_GAP;
            one_gap_reg     <= RST_ONE_GAP;
            pulse_reg       <= RST_PULSE;
            char_gap_reg    <= RST_CHAR_GAP;
            session_gap_reg <= RST_SESSION_GAP;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ZERO_GAP:    zero_gap_reg    <= cfg.data;
                REG_ONE_GAP:     one_gap_reg     <= cfg.data;
                REG_PULSE:       pulse_reg       <= cfg.data;
                REG_CHAR_GAP:    char_gap_reg    <= cfg.data;
                REG_SESSION_GAP: session_gap_reg <= cfg.data;
                default:         zero_gap_reg    <= zero_gap_reg;
            endcase
        end
    end

    // Fit register values to the tick counter width
    assign timing.zero_gap    = tick_t'(zero_gap_reg);
    assign timing.one_gap     = tick_t'(one_gap_reg);
    assign timing.pulse       = tick_t'(pulse_reg);
    assign timing.char_gap    = tick_t'(char_gap_reg);
    assign timing.session_gap = tick_t'(session_gap_reg);

    // Front: accept and decode cmd words, normalize character codes
    pdct_front u_front (
        .cmd       (cmd),
        .q_ready   (q_ready),
        .push      (push),
        .push_word (push_word)
    );

    // Queue: decouple the front from the back
    pdct_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_word  (push_word),
        .ready      (q_ready),
        .pop        (pop),
        .head_valid (q_head_valid),
        .head_word  (q_head_word)
    );

    // Back: advance the line state, register the result word
    pdct_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .timing     (timing),
        .head_valid (q_head_valid),
        .head_word  (q_head_word),
        .pop        (pop),
        .stat       (stat),
        .result     (result)
    );

`ifndef SYNTHESIS
    // A running segment always has ticks left
    a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> !stat.cnt_zero)
        else $error("segment running with zero ticks left");

    // A dropped send only happens while a job is running
    a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.rejected) |-> result.busy_res)
        else $error("rejected word reports idle transmitter");

    // A new result only follows a queued word
    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(q_head_valid))
        else $error("result appeared without a queued word");
`endif

endmodule
